[design/ngll_pkg.sv]
// types, constants and field arithmetic shared by the gll sentence parser
package ngll_pkg;

   localparam int POS_FRAC_DIGITS  = 5;
   localparam int TIME_FRAC_DIGITS = 2;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 104;

   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_NORTH = 8'h4E;
   localparam logic [7:0] CHAR_EAST  = 8'h45;
   localparam logic [7:0] CHAR_FIXED = 8'h41;
   localparam logic [7:0] CHAR_G     = 8'h47;
   localparam logic [7:0] CHAR_N     = 8'h4E;
   localparam logic [7:0] CHAR_L     = 8'h4C;

   localparam logic [2:0] ID_LEN = 3'd5;

   localparam logic [2:0] FIELD_ID       = 3'd0;
   localparam logic [2:0] FIELD_LAT      = 3'd1;
   localparam logic [2:0] FIELD_LAT_HEMI = 3'd2;
   localparam logic [2:0] FIELD_LNG      = 3'd3;
   localparam logic [2:0] FIELD_LNG_HEMI = 3'd4;
   localparam logic [2:0] FIELD_TIME     = 3'd5;
   localparam logic [2:0] FIELD_STATUS   = 3'd6;
   localparam logic [2:0] FIELD_LAST     = 3'd7;

   localparam logic [1:0] TOK_LEN_MAX = 2'd2;

   typedef struct packed {
      logic        point;
      logic        stop;
      logic        start;
   } num_flags_type;

   typedef struct packed {
      logic [2:0]  field;
      logic [2:0]  id_pos;
      logic        id_mis;
      logic [31:0] acc;
      logic [2:0]  frac;
      logic        sign;
      logic [7:0]  tok_char;
      logic [1:0]  tok_len;
   } field_state_type;

   typedef struct packed {
      logic [31:0] lat;
      logic [31:0] lng;
      logic [31:0] utc;
      logic        fix;
   } sentence_type;

   // expected message identifier, one character per position
   function automatic logic [7:0] id_char(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0:    ch = CHAR_G;
         3'd1:    ch = CHAR_N;
         3'd2:    ch = CHAR_G;
         3'd3:    ch = CHAR_L;
         3'd4:    ch = CHAR_L;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [19:0] pow_ten(input logic [2:0] k);
      logic [19:0] p;
      case (k)
         3'd0:    p = 20'd1;
         3'd1:    p = 20'd10;
         3'd2:    p = 20'd100;
         3'd3:    p = 20'd1000;
         3'd4:    p = 20'd10000;
         3'd5:    p = 20'd100000;
         3'd6:    p = 20'd1000000;
         default: p = 20'd1;
      endcase
      return p;
   endfunction

   function automatic logic [2:0] frac_digits(input logic [2:0] field);
      return (field == FIELD_TIME) ? 3'(TIME_FRAC_DIGITS) : 3'(POS_FRAC_DIGITS);
   endfunction

   // acc * 10 + digit, saturating at all ones
   function automatic logic [31:0] acc_digit(input logic [31:0] a, input logic [3:0] d);
      logic [35:0] v;
      v = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {32'd0, d};
      return (v[35:32] != 4'd0) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   function automatic logic [31:0] negate_sat(input logic [31:0] v);
      return (v == 32'h8000_0000) ? 32'h7FFF_FFFF : 32'd0 - v;
   endfunction

   // scale the magnitude up to the full fraction width and apply the sign
   function automatic logic [31:0] finish_number(input field_state_type fs);
      logic [2:0]  f;
      logic [2:0]  fc;
      logic [51:0] m;
      logic [31:0] mag;
      logic [31:0] res;
      f  = frac_digits(fs.field);
      fc = (fs.frac > f) ? f : fs.frac;
      m  = {20'd0, fs.acc} * {32'd0, pow_ten(3'(f - fc))};
      if (fs.sign) begin
         mag = (m > 52'h0_0000_8000_0000) ? 32'h8000_0000 : m[31:0];
         res = 32'd0 - mag;
      end else begin
         res = (m > 52'h0_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
      end
      return res;
   endfunction

   function automatic logic token_is(input field_state_type fs, input logic [7:0] ch);
      return (fs.tok_len == 2'd1) && (fs.tok_char == ch);
   endfunction

   // close the current field into the sentence record
   function automatic sentence_type commit_field(input field_state_type fs,
                                                 input sentence_type snt);
      sentence_type r;
      r = snt;
      if (!fs.id_mis) begin
         case (fs.field)
            FIELD_LAT:      r.lat = finish_number(fs);
            FIELD_LAT_HEMI: begin
               if (!token_is(fs, CHAR_NORTH)) r.lat = negate_sat(snt.lat);
            end
            FIELD_LNG:      r.lng = finish_number(fs);
            FIELD_LNG_HEMI: begin
               if (!token_is(fs, CHAR_EAST)) r.lng = negate_sat(snt.lng);
            end
            FIELD_TIME:     r.utc = finish_number(fs);
            FIELD_STATUS:   r.fix = token_is(fs, CHAR_FIXED);
            default: ;
         endcase
      end
      return r;
   endfunction

endpackage

[design/nmea_gll_field_parser_core.sv]
// GLL sentence parser: one body character per transaction in, one fix record per sentence out
//
// The req channel carries one character of the sentence body per transaction in
// req_tdata, with req_tlast set on the final character (the leading dollar sign and the
// checksum star are stripped upstream). The rsp channel carries one transaction per
// sentence: rsp_tuser is 1 when the identifier was not GNGLL, and then rsp_tdata is zero.
// Otherwise rsp_tdata holds latitude and longitude as signed ddmm.mmmmm times 1e5 and
// the UTC time as hhmmss.ss times 100, plus the fix valid flag.
// One character is taken every cycle while req_tready is high. The last character of a
// sentence loads the end-of-sentence stage, and from there the result moves on into the
// output register, where it can be taken: the closing field is finished (scale multiply,
// saturation, hemisphere sign) in a stage of its own.
// Reset clears the parse state and empties both result stages.
// When the receiver stalls, one result waits in the output register and a second in
// the end-of-sentence stage; only with both full does req_tready drop.
module nmea_gll_field_parser_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ngll_pkg::REQ_DATA_W-1:0]   req_tdata,  // [7:0] char_in
   input  logic                              req_tlast,  // end_of_sentence
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] latitude, [63:32] longitude, [95:64] utc_time, [96] fix_valid, rest zero
   output logic [ngll_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser   // [0] status
);
   import ngll_pkg::*;

   field_state_type end_fs, snap_fs_ff;
   sentence_type    end_snt, snap_snt_ff, snt_done;
   logic            snap_valid_ff, snap_valid_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic            rsp_user_ff, rsp_user_in;
   logic            in_accept, snap_load, snap_move, discard;

   assign req_tready = !(snap_valid_ff && rsp_valid_ff);
   assign in_accept  = req_tvalid && req_tready;
   assign snap_load  = in_accept && req_tlast;
   assign snap_move  = snap_valid_ff && (!rsp_valid_ff || rsp_tready);

   ngll_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .item_accept (in_accept),
      .char_in     (req_tdata[7:0]),
      .last_in     (req_tlast),
      .end_fs      (end_fs),
      .end_snt     (end_snt)
   );

   // close the last open field and format the record
   always_comb begin
      snt_done = commit_field(snap_fs_ff, snap_snt_ff);
      discard  = snap_fs_ff.id_mis |
                 ((snap_fs_ff.field == FIELD_ID) && (snap_fs_ff.id_pos != ID_LEN));
      if (discard) begin
         rsp_data_in = '0;
      end else begin
         rsp_data_in = {7'd0, snt_done.fix, snt_done.utc, snt_done.lng, snt_done.lat};
      end
      rsp_user_in   = discard;
      snap_valid_in = snap_load || (snap_valid_ff && !snap_move);
      rsp_valid_in  = snap_move || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_load) begin
         snap_fs_ff  <= end_fs;
         snap_snt_ff <= end_snt;
      end
      if (snap_move) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[design/ngll_parse.sv]
// per-character field tracking and number accumulation for one sentence
module ngll_parse (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_accept,
   input  logic [7:0]               char_in,
   input  logic                     last_in,
   output ngll_pkg::field_state_type end_fs,
   output ngll_pkg::sentence_type    end_snt
);
   import ngll_pkg::*;

   field_state_type fs_ff, fs_in, fs_feed;
   num_flags_type   flags_ff, flags_in, flags_feed;
   sentence_type    snt_ff, snt_in;
   logic            is_comma;

   assign is_comma = (char_in == CHAR_COMMA);

   // effect of one non-comma character on the open field
   always_comb begin
      fs_feed    = fs_ff;
      flags_feed = flags_ff;
      if (fs_ff.field == FIELD_ID) begin
         if (fs_ff.id_pos < ID_LEN && char_in == id_char(fs_ff.id_pos)) begin
            fs_feed.id_pos = fs_ff.id_pos + 3'd1;
         end else begin
            fs_feed.id_mis = 1'b1;
         end
      end else if (!fs_ff.id_mis) begin
         case (fs_ff.field)
            FIELD_LAT, FIELD_LNG, FIELD_TIME: begin
               if (!flags_ff.stop) begin
                  if (!flags_ff.start && (char_in == CHAR_PLUS || char_in == CHAR_MINUS)) begin
                     flags_feed.start = 1'b1;
                     if (char_in == CHAR_MINUS) fs_feed.sign = 1'b1;
                  end else if (char_in inside {[CHAR_ZERO:CHAR_NINE]}) begin
                     flags_feed.start = 1'b1;
                     if (!flags_ff.point) begin
                        fs_feed.acc = acc_digit(fs_ff.acc, char_in[3:0]);
                     end else if (fs_ff.frac < frac_digits(fs_ff.field)) begin
                        fs_feed.acc  = acc_digit(fs_ff.acc, char_in[3:0]);
                        fs_feed.frac = fs_ff.frac + 3'd1;
                     end
                  end else if (char_in == CHAR_POINT && !flags_ff.point) begin
                     flags_feed.point = 1'b1;
                     flags_feed.start = 1'b1;
                  end else begin
                     flags_feed.stop = 1'b1;
                  end
               end
            end
            FIELD_LAT_HEMI, FIELD_LNG_HEMI, FIELD_STATUS: begin
               if (fs_ff.tok_len == 2'd0) fs_feed.tok_char = char_in;
               if (fs_ff.tok_len < TOK_LEN_MAX) fs_feed.tok_len = fs_ff.tok_len + 2'd1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      fs_in    = fs_ff;
      flags_in = flags_ff;
      snt_in   = snt_ff;
      if (item_accept) begin
         if (last_in) begin
            // the sentence leaves through end_fs/end_snt; start over
            fs_in    = '0;
            flags_in = '0;
            snt_in   = '0;
         end else if (is_comma) begin
            snt_in        = commit_field(fs_ff, snt_ff);
            fs_in         = '0;
            flags_in      = '0;
            fs_in.field   = (fs_ff.field == FIELD_LAST) ? FIELD_LAST : fs_ff.field + 3'd1;
            fs_in.id_pos  = fs_ff.id_pos;
            fs_in.id_mis  = fs_ff.id_mis |
                            ((fs_ff.field == FIELD_ID) && (fs_ff.id_pos != ID_LEN));
         end else begin
            fs_in    = fs_feed;
            flags_in = flags_feed;
         end
      end
   end

   // a final comma closes the field as it stands; any other final character is fed first
   assign end_fs  = is_comma ? fs_ff : fs_feed;
   assign end_snt = snt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_ff    <= '0;
         flags_ff <= '0;
         snt_ff   <= '0;
      end else begin
         fs_ff    <= fs_in;
         flags_ff <= flags_in;
         snt_ff   <= snt_in;
      end
   end

endmodule

[design/ngll_checker.sv]
// port-level checks for the gll sentence parser, bound to the top level
module ngll_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tlast,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ngll_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);
   import ngll_pkg::*;

   // a stalled result keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // a discarded sentence carries an all-zero record
   a_discard_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("discard result with nonzero data");

   // a fresh result follows an accepted last character, by way of the end-of-sentence stage
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast, 2))
      else $error("result without end of sentence");

   // input is held off only while a result is waiting
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no pending result");

   // both stages stay full while the receiver stalls
   a_full_stays: assert property (@(posedge clock) disable iff (reset)
      !req_tready && !rsp_tready |=> !req_tready)
      else $error("ready returned while receiver stalled");

endmodule

bind nmea_gll_field_parser_core ngll_checker u_ngll_checker (.*);

[dv/tb.sv]
// self-checking testbench for the gll sentence parser: random body characters, predicted fix records
module tb;
   import ngll_pkg::*;

   typedef struct {
      logic [7:0] ch;
      logic       last;
      logic       hold;   // wait for all outstanding results before sending
   } body_char_type;

   typedef struct packed {
      logic        status;
      logic [31:0] lat;
      logic [31:0] lng;
      logic [31:0] utc;
      logic        fix;
   } fix_rec_type;

   localparam logic [7:0] GLL_ID [5] = '{CHAR_G, CHAR_N, CHAR_G, CHAR_L, CHAR_L};

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   nmea_gll_field_parser_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   body_char_type pending_chars[$];
   fix_rec_type   expected_fixes[$];
   logic [7:0]  sentence_buf[$];
   int          mismatches = 0;
   int          chars_queued = 0;
   int          sentences_queued = 0;

   // parse state of the predictor
   logic [2:0]  p_field = '0;
   logic [2:0]  p_idpos = '0;
   logic        p_idbad = 1'b0;
   logic [31:0] p_acc = '0;
   logic [2:0]  p_frac = '0;
   logic        p_neg = 1'b0;
   logic        p_point = 1'b0;
   logic        p_stop = 1'b0;
   logic        p_started = 1'b0;
   logic [7:0]  p_tchar = '0;
   logic [1:0]  p_tlen = '0;
   logic [31:0] p_lat = '0;
   logic [31:0] p_lng = '0;
   logic [31:0] p_utc = '0;
   logic        p_fix = 1'b0;

   function automatic int frac_width(input logic [2:0] field);
      return (field == FIELD_TIME) ? TIME_FRAC_DIGITS : POS_FRAC_DIGITS;
   endfunction

   function automatic logic [31:0] ten_acc(input logic [31:0] a, input logic [7:0] d);
      logic [63:0] v;
      v = {32'd0, a} * 64'd10 + {56'd0, d};
      return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   function automatic logic [31:0] flip_sat(input logic [31:0] v);
      return (v == 32'h8000_0000) ? 32'h7FFF_FFFF : 32'd0 - v;
   endfunction

   function automatic logic [31:0] scaled_value();
      int          f;
      int          fc;
      logic [63:0] m;
      f  = frac_width(p_field);
      fc = (int'(p_frac) > f) ? f : int'(p_frac);
      m  = {32'd0, p_acc};
      for (int i = 0; i < f - fc; i++) m = m * 64'd10;
      if (p_neg) begin
         if (m > 64'h8000_0000) m = 64'h8000_0000;
         return 32'd0 - m[31:0];
      end
      if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
      return m[31:0];
   endfunction

   function automatic logic single_char(input logic [7:0] ch);
      return (p_tlen == 2'd1) && (p_tchar == ch);
   endfunction

   task automatic clear_field();
      p_acc     = '0;
      p_frac    = '0;
      p_neg     = 1'b0;
      p_point   = 1'b0;
      p_stop    = 1'b0;
      p_started = 1'b0;
      p_tchar   = '0;
      p_tlen    = '0;
   endtask

   task automatic take_numeric(input logic [7:0] c);
      if (p_stop) return;
      if (!p_started && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
         p_started = 1'b1;
         if (c == CHAR_MINUS) p_neg = 1'b1;
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         p_started = 1'b1;
         if (!p_point) begin
            p_acc = ten_acc(p_acc, c - CHAR_ZERO);
         end else if (int'(p_frac) < frac_width(p_field)) begin
            p_acc  = ten_acc(p_acc, c - CHAR_ZERO);
            p_frac = p_frac + 3'd1;
         end
      end else if (c == CHAR_POINT && !p_point) begin
         p_point   = 1'b1;
         p_started = 1'b1;
      end else begin
         p_stop = 1'b1;
      end
   endtask

   task automatic take_char(input logic [7:0] c);
      if (p_field == FIELD_ID) begin
         if (p_idpos < ID_LEN && c == GLL_ID[p_idpos]) p_idpos = p_idpos + 3'd1;
         else p_idbad = 1'b1;
      end else if (!p_idbad) begin
         if (p_field == FIELD_LAT || p_field == FIELD_LNG || p_field == FIELD_TIME) begin
            take_numeric(c);
         end else if (p_field <= FIELD_STATUS) begin
            if (p_tlen == 2'd0) p_tchar = c;
            if (p_tlen < TOK_LEN_MAX) p_tlen = p_tlen + 2'd1;
         end
      end
   endtask

   task automatic close_field();
      if (p_field == FIELD_ID) begin
         if (p_idpos != ID_LEN) p_idbad = 1'b1;
      end else if (!p_idbad) begin
         case (p_field)
            FIELD_LAT:      p_lat = scaled_value();
            FIELD_LAT_HEMI: if (!single_char(CHAR_NORTH)) p_lat = flip_sat(p_lat);
            FIELD_LNG:      p_lng = scaled_value();
            FIELD_LNG_HEMI: if (!single_char(CHAR_EAST)) p_lng = flip_sat(p_lng);
            FIELD_TIME:     p_utc = scaled_value();
            FIELD_STATUS:   p_fix = single_char(CHAR_FIXED);
            default: ;
         endcase
      end
      clear_field();
   endtask

   // advance the parse by one accepted character, queue the fix record at sentence end
   task automatic track_char(input logic [7:0] c, input logic eos);
      fix_rec_type r;
      if (c == CHAR_COMMA) begin
         close_field();
         if (p_field != FIELD_LAST) p_field = p_field + 3'd1;
      end else begin
         take_char(c);
      end
      if (eos) begin
         if (c != CHAR_COMMA) close_field();
         r = '0;
         if (p_idbad) begin
            r.status = 1'b1;
         end else begin
            r.lat = p_lat;
            r.lng = p_lng;
            r.utc = p_utc;
            r.fix = p_fix;
         end
         expected_fixes.push_back(r);
         p_field = '0;
         p_idpos = '0;
         p_idbad = 1'b0;
         p_lat   = '0;
         p_lng   = '0;
         p_utc   = '0;
         p_fix   = 1'b0;
      end
   endtask

   // sentence building
   task automatic put_byte(input logic [7:0] b);
      sentence_buf.push_back(b);
   endtask

   task automatic put_str(input string s);
      for (int i = 0; i < s.len(); i++) sentence_buf.push_back(s[i]);
   endtask

   task automatic put_digit();
      put_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
   endtask

   task automatic close_sentence(input logic hold);
      body_char_type it;
      int            n;
      n = sentence_buf.size();
      for (int i = 0; i < n; i++) begin
         it.ch   = sentence_buf.pop_front();
         it.last = (i == n - 1);
         it.hold = hold && (i == 0);
         pending_chars.push_back(it);
      end
      chars_queued += n;
      sentences_queued++;
   endtask

   task automatic put_number(input int max_int, input int max_frac);
      int n;
      if ($urandom_range(0, 11) == 0) return;
      case ($urandom_range(0, 5))
         0: put_byte(CHAR_PLUS);
         1: put_byte(CHAR_MINUS);
         default: ;
      endcase
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 13) : $urandom_range(0, max_int);
      repeat (n) put_digit();
      if ($urandom_range(0, 3) != 0) begin
         put_byte(CHAR_POINT);
         repeat ($urandom_range(0, max_frac)) put_digit();
      end
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 3))
            0: put_byte(CHAR_POINT);
            1: put_byte(CHAR_MINUS);
            2: put_byte(CHAR_PLUS);
            default: put_byte(8'($urandom_range(0, 255)));
         endcase
         repeat ($urandom_range(0, 3)) put_digit();
      end
   endtask

   task automatic put_token(input logic [7:0] good, input logic [7:0] other);
      case ($urandom_range(0, 7))
         0, 1, 2: put_byte(good);
         3, 4:    put_byte(other);
         5:       ;
         6: begin
            put_byte(good);
            put_byte(good);
         end
         default: put_byte(8'($urandom_range(0, 255)));
      endcase
   endtask

   // quiet stretches: no idling on either side
   logic [7:0] calm_count = '0;
   logic       calm = 1'b0;
   always @(posedge clock) begin
      calm_count <= calm_count + 8'd1;
      if (calm_count == 8'd0) calm <= ($urandom_range(0, 3) == 0);
   end

   // driver
   body_char_type drv_cur;
   int            drv_gap = 0;
   always @(posedge clock) begin : drive
      logic nx_valid;
      if (reset) begin
         req_tvalid <= 1'b0;
         drv_gap = 0;
      end else begin
         nx_valid = req_tvalid;
         if (req_tvalid && req_tready) begin
            track_char(drv_cur.ch, drv_cur.last);
            drv_gap  = calm ? 0 : $urandom_range(0, 3);
            nx_valid = 1'b0;
         end
         if (!nx_valid) begin
            if (drv_gap > 0) begin
               drv_gap--;
            end else if (pending_chars.size() != 0 &&
                         !(pending_chars[0].hold && expected_fixes.size() != 0)) begin
               drv_cur = pending_chars.pop_front();
               req_tdata <= drv_cur.ch;
               req_tlast <= drv_cur.last;
               nx_valid  = 1'b1;
            end
         end
         req_tvalid <= nx_valid;
      end
   end

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
         mismatches++;
      end
   endtask

   // monitor
   int rdy_hold = 0;
   always @(posedge clock) begin : watch
      fix_rec_type want;
      if (reset) begin
         rsp_tready <= 1'b1;
         rdy_hold = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_fixes.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual tuser %b tdata %h",
                        $time, rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_fixes.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_tuser));
               check_field("latitude", want.lat, rsp_tdata[31:0]);
               check_field("longitude", want.lng, rsp_tdata[63:32]);
               check_field("utc_time", want.utc, rsp_tdata[95:64]);
               check_field("fix_valid", 32'(want.fix), 32'(rsp_tdata[96]));
               check_field("padding", 32'd0, 32'(rsp_tdata[RSP_DATA_W-1:97]));
            end
            rdy_hold = calm ? 0 : $urandom_range(0, 3);
            rsp_tready <= (rdy_hold == 0);
         end else if (!rsp_tready) begin
            if (rdy_hold > 1) begin
               rdy_hold--;
            end else begin
               rdy_hold = 0;
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   initial begin
      #4_000_000;
      $display("tb: done, errors");
      $finish;
   end

   initial begin
      int   kind;
      int   k;
      logic hold;

      // directed sentences
      put_str("GNGLL,4916.45,N,12311.12,W,225444,A");
      close_sentence(1'b0);
      put_str("GPGLL,1,N");
      close_sentence(1'b0);
      put_str("GNGLL");
      close_sentence(1'b0);
      put_str("GNGLL,");
      close_sentence(1'b0);
      // saturation of both signs, truncated time fraction, two-character status
      put_str("GNGLL,-99999999999,S,4294967296.9,E,12.3456,AA");
      close_sentence(1'b0);
      // most negative value negated, empty fields, extra fields
      put_str("GNGLL,-21474.83648,X,,N,,V,x,y,z");
      close_sentence(1'b0);
      // character zero and all ones stop a number
      put_str("GNGLL,1");
      put_byte(8'h00);
      put_str("2,N,3");
      put_byte(8'hFF);
      put_str(",E,1..5,A");
      close_sentence(1'b0);
      put_str("GNGLL,+-7,N,-.5,E,+,A");
      close_sentence(1'b0);
      put_str("GNGLLL,1");
      close_sentence(1'b0);
      put_str("GNGL,1");
      close_sentence(1'b0);
      put_str(",");
      close_sentence(1'b0);
      put_str("GNGLL,1,N,");
      close_sentence(1'b0);

      // random sentences, mostly well formed
      hold = 1'b1;
      while (chars_queued < 1400) begin
         kind = $urandom_range(0, 19);
         if (kind == 0) begin
            repeat ($urandom_range(1, 12)) begin
               if ($urandom_range(0, 3) == 0) put_byte(CHAR_COMMA);
               else put_byte(8'($urandom_range(0, 255)));
            end
         end else begin
            put_str("GNGLL");
            if (kind == 1) begin
               k = $urandom_range(0, 5);
               if (k < 5) sentence_buf[k] = 8'($urandom_range(0, 255));
               else put_byte(8'($urandom_range(0, 255)));
            end
            put_byte(CHAR_COMMA);
            put_number(4, 7);
            put_byte(CHAR_COMMA);
            put_token(CHAR_NORTH, "S");
            put_byte(CHAR_COMMA);
            put_number(5, 7);
            put_byte(CHAR_COMMA);
            put_token(CHAR_EAST, "W");
            put_byte(CHAR_COMMA);
            put_number(6, 4);
            put_byte(CHAR_COMMA);
            put_token(CHAR_FIXED, "V");
            if ($urandom_range(0, 7) == 0) put_str(",D,12");
         end
         if ($urandom_range(0, 5) == 0 && sentence_buf.size() > 1) begin
            k = $urandom_range(1, sentence_buf.size());
            while (sentence_buf.size() > k) void'(sentence_buf.pop_back());
         end
         close_sentence(hold);
         hold = ($urandom_range(0, 24) == 0);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_chars.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_fixes.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

[nmea_gll_field_parser_core.f]
design/ngll_pkg.sv
design/ngll_parse.sv
design/nmea_gll_field_parser_core.sv
design/ngll_checker.sv
dv/tb.sv
